// ===== rtl/lrs_pkg.sv =====
// Package for the link reconnect supervisor: action codes, register indexes,
// reset values and the state, config and result structs.
// No dependencies.
package lrs_pkg;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_LINK_UP    = 3'd1,
    ACT_LINK_LOST  = 3'd2,
    ACT_RETRY_TOUT = 3'd3,
    ACT_RESTART    = 3'd4,
    ACT_START      = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    REG_RETRY_TIMEOUT = 3'd0,
    REG_BACKOFF_MIN   = 3'd1,
    REG_BACKOFF_MAX   = 3'd2,
    REG_RESTART_AFTER = 3'd3,
    REG_CAND_COUNT    = 3'd4
  } reg_index_t;

  localparam int unsigned CfgDataW  = 31;
  localparam int unsigned CfgIndexW = 3;

  localparam logic [19:0] RetryTimeoutRst = 20'd10000;
  localparam logic [19:0] BackoffMinRst   = 20'd3000;
  localparam logic [19:0] BackoffMaxRst   = 20'd60000;
  localparam logic [30:0] RestartAfterRst = 31'd300000;
  localparam logic [1:0]  NetCountRst     = 2'd2;

  typedef struct packed {
    logic [19:0] retry_timeout;
    logic [19:0] backoff_min;
    logic [19:0] backoff_max;
    logic [30:0] restart_after;
    logic [1:0]  cand_count;
  } cfg_t;

  typedef struct packed {
    logic        link_state;
    logic        retry_pending;
    logic [31:0] retry_start_time;
    logic [31:0] next_retry_time;
    logic [19:0] current_backoff;
    logic [31:0] down_start_time;
    logic [31:0] last_restart_time;
    logic        next_network;
  } state_t;

  typedef struct packed {
    action_t action;
    logic    network_index;
    logic    link_is_up;
  } result_t;

endpackage

// ===== rtl/lrs_if.sv =====
// Request and result channel interfaces for the link reconnect supervisor.
// Depends on lrs_pkg.
interface lrs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        connected;
  logic        join_busy;
  logic        scan_busy;

  modport source (output valid, now_ms, connected, join_busy, scan_busy, input ready);
  modport sink (input valid, now_ms, connected, join_busy, scan_busy, output ready);
endinterface

interface lrs_out_if;
  logic              valid;
  logic              ready;
  lrs_pkg::action_t  action;
  logic              network_index;
  logic              link_is_up;

  modport source (output valid, action, network_index, link_is_up, input ready);
  modport sink (input valid, action, network_index, link_is_up, output ready);
endinterface

// ===== rtl/lrs_step.sv =====
// Next-state and action logic for one supervision tick.
// Depends on lrs_pkg.
module lrs_step (
  input  lrs_pkg::cfg_t    cfg,
  input  lrs_pkg::state_t  cur,
  input  logic [31:0]      now_ms,
  input  logic             connected,
  input  logic             join_busy,
  input  logic             scan_busy,
  output lrs_pkg::state_t  nxt,
  output lrs_pkg::result_t res
);

  logic [31:0] down_eff;
  logic [31:0] since_retry;
  logic [31:0] since_down;
  logic [31:0] since_restart;
  logic [31:0] until_retry;
  logic [20:0] doubled;
  logic [19:0] backoff_new;
  logic        restart_due;

  assign down_eff      = (cur.down_start_time == 32'd0) ? now_ms : cur.down_start_time;
  assign since_retry   = now_ms - cur.retry_start_time;
  assign since_down    = now_ms - down_eff;
  assign since_restart = now_ms - cur.last_restart_time;
  assign until_retry   = now_ms - cur.next_retry_time;
  assign doubled       = {cur.current_backoff, 1'b0};
  assign backoff_new   = (doubled > {1'b0, cfg.backoff_max}) ? cfg.backoff_max
                                                             : doubled[19:0];
  assign restart_due   = (since_down >= {1'b0, cfg.restart_after}) &&
                         ((cur.last_restart_time == 32'd0) ||
                          (since_restart >= {1'b0, cfg.restart_after}));

  always_comb begin
    nxt               = cur;
    res.action        = lrs_pkg::ACT_NONE;
    res.network_index = 1'b0;
    if (!join_busy) begin
      if (connected) begin
        if (!cur.link_state) begin
          nxt.link_state      = 1'b1;
          nxt.retry_pending   = 1'b0;
          nxt.current_backoff = cfg.backoff_min;
          nxt.down_start_time = 32'd0;
          res.action          = lrs_pkg::ACT_LINK_UP;
        end
      end else if (cur.link_state) begin
        nxt.link_state      = 1'b0;
        nxt.down_start_time = now_ms;
        nxt.current_backoff = cfg.backoff_min;
        nxt.next_retry_time = now_ms + {12'd0, cfg.backoff_min};
        res.action          = lrs_pkg::ACT_LINK_LOST;
      end else begin
        nxt.down_start_time = down_eff;
        if (cur.retry_pending) begin
          if (since_retry >= {12'd0, cfg.retry_timeout}) begin
            nxt.retry_pending   = 1'b0;
            nxt.current_backoff = backoff_new;
            nxt.next_retry_time = now_ms + {12'd0, backoff_new};
            res.action          = lrs_pkg::ACT_RETRY_TOUT;
          end
        end else if (restart_due) begin
          nxt.last_restart_time = now_ms;
          nxt.next_retry_time   = now_ms;
          res.action            = lrs_pkg::ACT_RESTART;
        end else if (!scan_busy && !until_retry[31]) begin
          // alternate candidates only when two or more are configured
          if (cfg.cand_count <= 2'd1) begin
            nxt.next_network = 1'b0;
          end else begin
            nxt.next_network  = ~cur.next_network;
            res.network_index = cur.next_network;
          end
          nxt.retry_pending    = 1'b1;
          nxt.retry_start_time = now_ms;
          res.action           = lrs_pkg::ACT_START;
        end
      end
    end
    res.link_is_up = nxt.link_state;
  end

endmodule

// ===== rtl/link_reconnect_supervisor_unit.sv =====
// Link reconnect supervisor top level: one request per tick, one result each.
// The result is registered and valid in the cycle after request acceptance.
// Throughput: 1 request per cycle; a held result stalls intake only if not taken.
// Reset (synchronous, rst_n low): link down, no retry pending, all times unset,
// backoff at 3000 ms, config registers at their defaults.
// Depends on lrs_pkg, lrs_if and lrs_step.
module link_reconnect_supervisor_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  lrs_in_if.sink                          in_if,
  lrs_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [lrs_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [lrs_pkg::CfgDataW-1:0]    cfg_wdata
);

  lrs_pkg::cfg_t    cfg_r;
  lrs_pkg::state_t  state_r;
  lrs_pkg::state_t  state_nxt;
  lrs_pkg::result_t res_nxt;
  lrs_pkg::result_t res_r;
  logic             out_valid_r;
  logic             in_acc;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  lrs_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .now_ms    (in_if.now_ms),
    .connected (in_if.connected),
    .join_busy (in_if.join_busy),
    .scan_busy (in_if.scan_busy),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_timeout <= lrs_pkg::RetryTimeoutRst;
      cfg_r.backoff_min   <= lrs_pkg::BackoffMinRst;
      cfg_r.backoff_max   <= lrs_pkg::BackoffMaxRst;
      cfg_r.restart_after <= lrs_pkg::RestartAfterRst;
      cfg_r.cand_count    <= lrs_pkg::NetCountRst;
    end else if (cfg_we) begin
      case (cfg_index)
        lrs_pkg::REG_RETRY_TIMEOUT: cfg_r.retry_timeout <= cfg_wdata[19:0];
        lrs_pkg::REG_BACKOFF_MIN:   cfg_r.backoff_min   <= cfg_wdata[19:0];
        lrs_pkg::REG_BACKOFF_MAX:   cfg_r.backoff_max   <= cfg_wdata[19:0];
        lrs_pkg::REG_RESTART_AFTER: cfg_r.restart_after <= cfg_wdata[30:0];
        lrs_pkg::REG_CAND_COUNT:    cfg_r.cand_count    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.link_state        <= 1'b0;
      state_r.retry_pending     <= 1'b0;
      state_r.retry_start_time  <= 32'd0;
      state_r.next_retry_time   <= 32'd0;
      state_r.current_backoff   <= lrs_pkg::BackoffMinRst;
      state_r.down_start_time   <= 32'd0;
      state_r.last_restart_time <= 32'd0;
      state_r.next_network      <= 1'b0;
      out_valid_r               <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; load on every accepted request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.action        = res_r.action;
  assign out_if.network_index = res_r.network_index;
  assign out_if.link_is_up    = res_r.link_is_up;

`ifndef SYNTHESIS
  a_pending_only_down: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.retry_pending |-> !state_r.link_state)
    else $error("retry pending while link is up");

  a_index_only_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.network_index) |-> (out_if.action == lrs_pkg::ACT_START))
    else $error("network index set on non-retry action");

  a_join_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.join_busy) |=> ($stable(state_r) && (res_r.action == lrs_pkg::ACT_NONE)))
    else $error("join-busy tick changed state");

  a_link_up_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (res_r.link_is_up == state_r.link_state))
    else $error("reported link state differs from stored state");
`endif

endmodule
